/* hdl/oesf_pkg.sv */
// Shared types and constants for the one-euro sensor filter.
// Used by oesf_ctrl, oesf_dp and the top level one_euro_sensor_filter.
package oesf_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam logic [15:0] SAMPLE_MASK = 16'((32'd1 << SAMPLE_BITS) - 1);

  // round(2*pi * 2^16)
  localparam logic [18:0] TWO_PI_Q16 = 19'd411775;

  // quotient bits of the smoothing-factor division (alpha <= 2^16)
  localparam int DIV_STEPS = 17;

  // configuration register indexes
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_RATE   = 3'd1;
  localparam logic [2:0] REG_MINCUT = 3'd2;
  localparam logic [2:0] REG_BETA   = 3'd3;
  localparam logic [2:0] REG_DERCUT = 3'd4;

  localparam logic [15:0] RATE_RESET = 16'd1000;

  // filter modes
  localparam logic [1:0] MODE_BYPASS = 2'd0;
  localparam logic [1:0] MODE_LOWPASS = 2'd1;
  localparam logic [1:0] MODE_EURO = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DER_MUL,
    OP_DER_SAT,
    OP_ALPHA_MUL,
    OP_ALPHA_SETUP,
    OP_DIV_STEP,
    OP_BL_DIFF,
    OP_BL_LO,
    OP_BL_HI,
    OP_BL_ACC,
    OP_BL_END,
    OP_CUT_LO,
    OP_CUT_HI,
    OP_CUT_ACC,
    OP_CUT_SAT,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic deriv;   // current alpha/blend pass works on the derivative
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       out_busy;
  } stat_t;

endpackage

/* hdl/one_euro_sensor_filter.sv */
// Top level of the one-euro sensor filter: sequencer plus datapath.
// Depends on oesf_pkg, oesf_ctrl and oesf_dp.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  raw_sample (16 b)
//   out      out_valid/out_stall  filtered_value (32 b, Q16.16)
//   cfg      cfg_we               cfg_index (3 b), cfg_data (16 b)
//
// The bit-serial division of 17 steps runs once per smoothing factor, and
// every product of the datapath is formed in the single
// shared multiplier. One request is in work at a time; the next is taken
// once the result sits in the output register. Reset is synchronous and
// needs no clearing pass. A stalled output holds the block in its emit step.
module one_euro_sensor_filter import oesf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] raw_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] filtered_value
);

  cmd_t  cmd;
  stat_t stat;

  oesf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  oesf_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .raw_sample     (raw_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .filtered_value (filtered_value),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

/* hdl/oesf_ctrl.sv */
// Sequencer for the one-euro sensor filter: steps the datapath through
// derivative, smoothing-factor division, blend and cutoff phases. Uses oesf_pkg.
module oesf_ctrl import oesf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_DMUL  = 16'h0002,
    S_DSAT  = 16'h0004,
    S_AMUL  = 16'h0008,
    S_ASET  = 16'h0010,
    S_ADIV  = 16'h0020,
    S_BDIFF = 16'h0040,
    S_BLO   = 16'h0080,
    S_BHI   = 16'h0100,
    S_BACC  = 16'h0200,
    S_BEND  = 16'h0400,
    S_CLO   = 16'h0800,
    S_CHI   = 16'h1000,
    S_CACC  = 16'h2000,
    S_CSAT  = 16'h4000,
    S_EMIT  = 16'h8000
  } state_t;

  state_t     state, state_next;
  logic       deriv_pass, deriv_pass_next;
  logic [4:0] cnt, cnt_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    deriv_pass_next = deriv_pass;
    cnt_next = cnt;
    cmd.op = OP_NONE;
    cmd.deriv = deriv_pass;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          case (stat.mode)
            MODE_LOWPASS: begin
              deriv_pass_next = 1'b0;
              state_next = S_AMUL;
            end
            MODE_EURO: begin
              deriv_pass_next = 1'b1;
              state_next = S_DMUL;
            end
            default: state_next = S_EMIT;
          endcase
        end
      end
      S_DMUL: begin
        cmd.op = OP_DER_MUL;
        state_next = S_DSAT;
      end
      S_DSAT: begin
        cmd.op = OP_DER_SAT;
        state_next = S_AMUL;
      end
      S_AMUL: begin
        cmd.op = OP_ALPHA_MUL;
        state_next = S_ASET;
      end
      S_ASET: begin
        cmd.op = OP_ALPHA_SETUP;
        cnt_next = '0;
        state_next = S_ADIV;
      end
      S_ADIV: begin
        cmd.op = OP_DIV_STEP;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(DIV_STEPS - 1)) state_next = S_BDIFF;
      end
      S_BDIFF: begin
        cmd.op = OP_BL_DIFF;
        state_next = S_BLO;
      end
      S_BLO: begin
        cmd.op = OP_BL_LO;
        state_next = S_BHI;
      end
      S_BHI: begin
        cmd.op = OP_BL_HI;
        state_next = S_BACC;
      end
      S_BACC: begin
        cmd.op = OP_BL_ACC;
        state_next = S_BEND;
      end
      S_BEND: begin
        cmd.op = OP_BL_END;
        state_next = deriv_pass ? S_CLO : S_EMIT;
      end
      S_CLO: begin
        cmd.op = OP_CUT_LO;
        state_next = S_CHI;
      end
      S_CHI: begin
        cmd.op = OP_CUT_HI;
        state_next = S_CACC;
      end
      S_CACC: begin
        cmd.op = OP_CUT_ACC;
        state_next = S_CSAT;
      end
      S_CSAT: begin
        cmd.op = OP_CUT_SAT;
        deriv_pass_next = 1'b0;
        state_next = S_AMUL;
      end
      S_EMIT: begin
        // hold until the output register can take the request
        if (!stat.out_busy) begin
          cmd.op = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      deriv_pass <= 1'b0;
      cnt <= '0;
    end else begin
      state <= state_next;
      deriv_pass <= deriv_pass_next;
      cnt <= cnt_next;
    end
  end

endmodule

/* hdl/oesf_dp.sv */
// Datapath of the one-euro sensor filter: configuration, filter state, one shared
// multiplier, a bit-serial divider and the output register. Uses oesf_pkg.
module oesf_dp import oesf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [15:0] raw_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] filtered_value,
  input  cmd_t        cmd,
  output stat_t       stat
);

  // configuration
  logic [1:0]  mode;
  logic [15:0] rate, min_cut, beta, der_cut;

  // filter state
  logic [15:0] prev;
  logic [31:0] sv;
  logic [47:0] sd;

  // per-item working registers
  logic [15:0]        sample;
  logic [47:0]        dsat;
  logic [15:0]        cut;
  logic signed [43:0] prod;
  logic [40:0]        den, rem;
  logic [16:0]        nbits, q, alpha;
  logic               czero;
  logic signed [48:0] diff;
  logic signed [67:0] acc;

  logic signed [25:0] mul_a;
  logic signed [17:0] mul_b;
  logic [15:0]        cutoff;
  logic [47:0]        xv, yv, mag;
  logic [34:0]        w;
  logic [41:0]        rem2;
  logic [67:0]        bl_sum;
  logic [47:0]        bl_res;
  logic [33:0]        dp34;
  logic [51:0]        cut_hi;
  logic [16:0]        cut_sum;
  logic               bypass, out_take;

  assign bypass = (mode != MODE_LOWPASS) && (mode != MODE_EURO);
  assign out_take = out_valid && !out_stall;
  assign stat.mode = mode;
  assign stat.out_busy = out_valid && out_stall;

  assign cutoff = cmd.deriv ? der_cut : ((mode == MODE_EURO) ? cut : min_cut);
  assign xv = cmd.deriv ? {~dsat[47], dsat[46:0]} : {16'd0, sample, 16'd0};
  assign yv = cmd.deriv ? {~sd[47], sd[46:0]} : {16'd0, sv};
  assign mag = sd[47] ? (48'd0 - sd) : sd;
  assign w = prod[34:0];
  assign rem2 = {rem, nbits[16]};
  assign bl_sum = 68'(acc) + 68'd32768;
  assign bl_res = bl_sum[63:16];
  assign dp34 = prod[33:0];
  assign cut_hi = 52'(acc[67:16]);
  assign cut_sum = {1'b0, cut_hi[15:0]} + {1'b0, min_cut};

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_DER_MUL: begin
        mul_a = 26'(signed'({1'b0, sample} - {1'b0, prev}));
        mul_b = {2'b00, rate};
      end
      OP_ALPHA_MUL: begin
        mul_a = {7'd0, TWO_PI_Q16};
        mul_b = {2'b00, cutoff};
      end
      OP_BL_LO: begin
        mul_a = {2'b00, diff[23:0]};
        mul_b = {1'b0, alpha};
      end
      OP_BL_HI: begin
        mul_a = {diff[48], diff[48:24]};
        mul_b = {1'b0, alpha};
      end
      OP_CUT_LO: begin
        mul_a = {2'b00, mag[23:0]};
        mul_b = {2'b00, beta};
      end
      OP_CUT_HI: begin
        mul_a = {2'b00, mag[47:24]};
        mul_b = {2'b00, beta};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // configuration and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_BYPASS;
      rate <= RATE_RESET;
      min_cut <= '0;
      beta <= '0;
      der_cut <= '0;
      prev <= '0;
      sv <= '0;
      sd <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   mode <= cfg_data[1:0];
        REG_RATE:   rate <= cfg_data;
        REG_MINCUT: min_cut <= cfg_data;
        REG_BETA:   beta <= cfg_data;
        REG_DERCUT: der_cut <= cfg_data;
        default: ;
      endcase
      if (cfg_index <= REG_DERCUT) begin
        prev <= '0;
        sv <= '0;
        sd <= '0;
      end
    end else begin
      case (cmd.op)
        OP_LOAD: if (bypass) prev <= raw_sample & SAMPLE_MASK;
        OP_DER_SAT: prev <= sample;
        OP_BL_END: begin
          if (cmd.deriv) sd <= {~bl_res[47], bl_res[46:0]};
          else sv <= bl_res[31:0];
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: sample <= raw_sample & SAMPLE_MASK;
      OP_DER_SAT: begin
        // saturate (prod << 16) to a signed 48-bit value
        if (dp34[33:31] == 3'b000 || dp34[33:31] == 3'b111) dsat <= {dp34[31:0], 16'd0};
        else if (dp34[33]) dsat <= {1'b1, 47'd0};
        else dsat <= {1'b0, {47{1'b1}}};
      end
      OP_ALPHA_SETUP: begin
        den <= 41'(w) + {1'b0, rate, 24'd0};
        rem <= 41'(w[34:1]);
        nbits <= {w[0], 16'd0};
        q <= '0;
        czero <= (cutoff == 16'd0);
      end
      OP_DIV_STEP: begin
        nbits <= {nbits[15:0], 1'b0};
        if (rem2 >= {1'b0, den}) begin
          rem <= 41'(rem2 - {1'b0, den});
          q <= {q[15:0], 1'b1};
        end else begin
          rem <= rem2[40:0];
          q <= {q[15:0], 1'b0};
        end
      end
      OP_BL_DIFF: begin
        diff <= signed'({1'b0, xv}) - signed'({1'b0, yv});
        acc <= signed'({4'd0, yv, 16'd0});
        alpha <= czero ? 17'd0 : q;
      end
      OP_BL_HI: acc <= acc + 68'(prod);
      OP_BL_ACC: acc <= acc + (68'(prod) <<< 24);
      OP_CUT_HI: acc <= 68'(prod);
      OP_CUT_ACC: acc <= acc + (68'(prod) <<< 24);
      OP_CUT_SAT: begin
        if ((|cut_hi[51:16]) || cut_sum[16]) cut <= 16'hFFFF;
        else cut <= cut_sum[15:0];
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      filtered_value <= bypass ? {sample, 16'd0} : sv;
    end
  end

endmodule

/* tb/sv/one_euro_sensor_filter_tb.sv */
// Self-checking testbench for one_euro_sensor_filter: bypass, low-pass and one-euro modes.
// Depends on oesf_pkg and the RTL top level; predicts each filtered value in fixed point.
module one_euro_sensor_filter_tb;
  import oesf_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] raw_sample = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] filtered_value;

  localparam longint DER_MAX = 64'sd140737488355327;
  localparam longint DER_MIN = -64'sd140737488355328;
  localparam int     QUIET_LIMIT = 20000;

  // predictor copy of the registers and state
  logic [1:0]   mode_q;
  logic [15:0]  rate_q, mincut_q, beta_q, dercut_q;
  logic [15:0]  prev_q;
  logic [31:0]  smooth_q;
  longint       deriv_q;

  logic [31:0]  filtered_queue[$];
  int           errors = 0;
  int           sent = 0;
  int           received = 0;
  int           quiet = 0;
  bit           calm = 1'b0;
  int           in_gap = 0;
  int           out_gap = 0;

  one_euro_sensor_filter dut (.*);

  always #2 clk = ~clk;

  function automatic logic [63:0] smoothing_factor(input logic [15:0] cut);
    logic [63:0] w;
    if (cut == 0) return 64'd0;
    w = 64'(cut) * 64'd411775;
    return (w << 16) / (w + (64'(rate_q) << 24));
  endfunction

  function automatic logic [63:0] mix(input logic [63:0] a, input logic [63:0] x,
                                      input logic [63:0] y);
    return (a * x + (64'd65536 - a) * y + 64'd32768) >> 16;
  endfunction

  function automatic logic [31:0] predict_filtered(input logic [15:0] smp);
    logic [63:0] x, mag, cut;
    longint d;
    x = 64'(smp) << 16;
    if (mode_q == MODE_LOWPASS) begin
      smooth_q = 32'(mix(smoothing_factor(mincut_q), x, 64'(smooth_q)));
      return smooth_q;
    end else if (mode_q == MODE_EURO) begin
      d = (longint'(smp) - longint'(prev_q)) * longint'(rate_q) * 65536;
      if (d > DER_MAX) d = DER_MAX;
      if (d < DER_MIN) d = DER_MIN;
      deriv_q = longint'(mix(smoothing_factor(dercut_q), 64'(d - DER_MIN),
                             64'(deriv_q - DER_MIN))) + DER_MIN;
      prev_q = smp;
      mag = deriv_q < 0 ? 64'(-deriv_q) : 64'(deriv_q);
      cut = ((64'(beta_q) * mag) >> 16) + 64'(mincut_q);
      if (cut > 64'd65535) cut = 64'd65535;
      smooth_q = 32'(mix(smoothing_factor(16'(cut)), x, 64'(smooth_q)));
      return smooth_q;
    end
    prev_q = smp;
    return {smp, 16'h0};
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODE:   mode_q = val[1:0];
      REG_RATE:   rate_q = val;
      REG_MINCUT: mincut_q = val;
      REG_BETA:   beta_q = val;
      REG_DERCUT: dercut_q = val;
      default: return;
    endcase
    prev_q = '0;
    smooth_q = '0;
    deriv_q = 0;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (filtered_queue.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic setup(input logic [1:0] m, input logic [15:0] r, input logic [15:0] mc,
                       input logic [15:0] b, input logic [15:0] dc);
    drain();
    write_reg(REG_MODE, 16'(m));
    write_reg(REG_RATE, r);
    write_reg(REG_MINCUT, mc);
    write_reg(REG_BETA, b);
    write_reg(REG_DERCUT, dc);
  endtask

  // valid stays high after an accepted request unless an idle burst follows
  task automatic send_sample(input logic [15:0] smp);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (in_gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_sample <= smp;
    filtered_queue.push_back(predict_filtered(smp));
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // hold output stall in random bursts
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= (out_gap > 1);
    end else if ($urandom_range(0, 9) == 0) begin
      out_gap <= $urandom_range(1, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      received++;
      if (filtered_queue.size() == 0) begin
        $error("filtered_value: no request pending, actual %h", filtered_value);
        errors++;
      end else begin
        if (filtered_value !== filtered_queue[0]) begin
          $error("filtered_value: expected %h actual %h", filtered_queue[0], filtered_value);
          errors++;
        end
        void'(filtered_queue.pop_front());
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_bypass;
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h5A5A);
    setup(2'd3, 16'd1000, 16'd0, 16'd0, 16'd0);  // unused mode behaves as bypass
    send_sample(16'hA5A5);
    send_sample(16'h0001);
  endtask

  task automatic test_lowpass;
    setup(MODE_LOWPASS, 16'd1000, 16'h0A00, 16'd0, 16'd0);
    repeat (3) send_sample(16'hFFFF);
    send_sample(16'h0000);
    setup(MODE_LOWPASS, 16'd1, 16'hFFFF, 16'd0, 16'd0);
    send_sample(16'hFFFF);
    send_sample(16'h1234);
    setup(MODE_LOWPASS, 16'd65535, 16'd0, 16'hFFFF, 16'hFFFF);  // zero cutoff holds
    send_sample(16'hFFFF);
  endtask

  task automatic test_euro;
    setup(MODE_EURO, 16'd65535, 16'h0100, 16'hFFFF, 16'hFFFF);
    send_sample(16'hFFFF);   // saturating derivative and cutoff
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    setup(MODE_EURO, 16'd0, 16'h0200, 16'h0080, 16'h0100);  // zero rate
    send_sample(16'h8000);
    send_sample(16'h0001);
    setup(MODE_EURO, 16'd1000, 16'h0100, 16'h0010, 16'h0100);
    repeat (4) send_sample(16'($urandom));
    drain();
    write_reg(3'd6, 16'hFFFF);  // out-of-range index keeps state
    send_sample(16'h4000);
  endtask

  task automatic test_random;
    logic [15:0] base;
    for (int p = 0; p < 16; p++) begin
      if (p == 13) calm = 1'b1;
      setup(2'($urandom_range(0, 3)),
            16'($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(1, 2000)),
            16'($urandom), 16'($urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom),
            16'($urandom));
      base = 16'($urandom);
      for (int i = 0; i < 50; i++) begin
        // mostly a slow wander, sometimes a jump
        if ($urandom_range(0, 4) == 0) base = 16'($urandom);
        else base = base + 16'($urandom_range(0, 64)) - 16'd32;
        send_sample(base);
      end
    end
  endtask

  initial begin
    mode_q = MODE_BYPASS;
    rate_q = RATE_RESET;
    mincut_q = '0;
    beta_q = '0;
    dercut_q = '0;
    prev_q = '0;
    smooth_q = '0;
    deriv_q = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_bypass();
    test_lowpass();
    test_euro();
    test_random();
    drain();
    $display("Covered %0d requests, %0d results, all modes incl. saturation and zero rate.",
             sent, received);
    if (errors == 0 && filtered_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/oesf_pkg.sv
hdl/oesf_ctrl.sv
hdl/oesf_dp.sv
hdl/one_euro_sensor_filter.sv
tb/sv/one_euro_sensor_filter_tb.sv
